// ----- rtl/bounded_deque_with_value_delete_unit_defines.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDVD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BDVD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bdvd_pkg.sv -----
// shared types and constants for the bounded deque unit
// no dependencies
package bdvd_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int WORD_W       = 32;
    localparam int MODE_W       = 3;
    localparam int STATUS_W     = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_DELETE     = 3'd4,
        MODE_CLEAR      = 3'd5,
        MODE_READ_ALL   = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_DELETE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        logic occupied;
        logic tail;
        logic fill;
    } cell_pos_t;

endpackage

// ----- rtl/bdvd_cell.sv -----
// one storage cell of the deque row: holds a word, shifts to and from its neighbors
// depends on bdvd_pkg
module bdvd_cell
    import bdvd_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  cell_pos_t         pos,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] prev_word,
    input  logic [WORD_W-1:0] next_word,
    input  logic [WORD_W-1:0] wrap_word,
    input  logic              seen_in,
    output logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] pick_word,
    output logic              seen_out
);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              match;
    logic              hit;
    logic              pick;

    assign match    = pos.occupied & (data_reg == key);
    assign hit      = match & ~seen_in;
    assign seen_out = seen_in | match;
    assign word     = data_reg;

    assign pick      = ((cmd == CMD_DELETE) & hit) | ((cmd == CMD_POP_BACK) & pos.tail);
    assign pick_word = pick ? data_reg : '0;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd)
            CMD_PUSH_FRONT: data_next = prev_word;
            CMD_PUSH_BACK:
            begin
                if (pos.fill)
                begin
                    data_next = key;
                end
            end
            CMD_POP_FRONT: data_next = next_word;
            CMD_DELETE:
            begin
                if (seen_out)
                begin
                    data_next = next_word;
                end
            end
            CMD_ROTATE: data_next = pos.tail ? wrap_word : next_word;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- rtl/bounded_deque_with_value_delete_unit.sv -----
// channel   | handshake          | words
// op        | op_valid/op_stall  | mode, value
// res       | res_valid/res_stall| status, value_res, count, last
//
// one op per cycle while no result is stalled, for all modes but read all,
// which returns count words and takes no op until the last (one if empty);
// the cells rotate a place per word read, so cell 0 always feeds value_res.
// reset clears the count and the result valid flag, no clearing pass.
// a finished result sits in the output register while the next op is taken.
// depends on bdvd_pkg and bdvd_cell
module bounded_deque_with_value_delete_unit
    import bdvd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               op_valid,
    output logic                               op_stall,
    input  logic [MODE_W-1:0]                  mode,
    input  logic signed [WORD_W-1:0]           value,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [STATUS_W-1:0]                status,
    output logic signed [WORD_W-1:0]           value_res,
    output logic [$clog2(CAPACITY+1)-1:0]      count,
    output logic                               last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [CNT_W-1:0]  rd_left_reg, rd_left_next;
    logic              rd_active_reg, rd_active_next;
    logic              res_valid_reg, res_valid_next;
    status_t           status_reg,  status_next;
    logic [WORD_W-1:0] vres_reg,    vres_next;
    logic [CNT_W-1:0]  rcount_reg,  rcount_next;
    logic              last_reg,    last_next;

    cell_cmd_t         cmd;
    logic              op_fire;
    logic              rd_step;
    logic              out_free;
    logic              full;
    logic              empty;
    logic              found;
    logic [WORD_W-1:0] picked;

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic [WORD_W-1:0] cell_pick [CAPACITY];
    logic [CAPACITY:0] seen;

    assign out_free = ~res_valid_reg | ~res_stall;
    assign op_stall = rd_active_reg | (res_valid_reg & res_stall);
    assign op_fire  = op_valid & ~op_stall;
    assign rd_step  = rd_active_reg & out_free;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign seen[0]  = 1'b0;
    assign found    = seen[CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            cell_pos_t         pos;
            logic [WORD_W-1:0] prev_w;
            logic [WORD_W-1:0] next_w;

            assign pos.occupied = (CNT_W'(gi) < count_reg);
            assign pos.tail     = (CNT_W'(gi + 1) == count_reg);
            assign pos.fill     = (CNT_W'(gi) == count_reg);

            if (gi == 0)
            begin : g_head
                assign prev_w = value;
            end
            else
            begin : g_body
                assign prev_w = cell_word[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign next_w = value;
            end
            else
            begin : g_mid
                assign next_w = cell_word[gi+1];
            end

            bdvd_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .pos       (pos),
                .key       (value),
                .prev_word (prev_w),
                .next_word (next_w),
                .wrap_word (cell_word[0]),
                .seen_in   (seen[gi]),
                .word      (cell_word[gi]),
                .pick_word (cell_pick[gi]),
                .seen_out  (seen[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        picked = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            picked = picked | cell_pick[k];
        end
    end

    always_comb
    begin
        cmd            = CMD_HOLD;
        count_next     = count_reg;
        rd_left_next   = rd_left_reg;
        rd_active_next = rd_active_reg;
        res_valid_next = res_valid_reg & res_stall;
        status_next    = status_reg;
        vres_next      = vres_reg;
        rcount_next    = rcount_reg;
        last_next      = last_reg;

        if (rd_step)
        begin
            cmd            = CMD_ROTATE;
            res_valid_next = 1'b1;
            status_next    = ST_OK;
            vres_next      = cell_word[0];
            rcount_next    = count_reg;
            last_next      = (rd_left_reg == CNT_W'(1));
            rd_left_next   = rd_left_reg - CNT_W'(1);
            rd_active_next = (rd_left_reg > CNT_W'(1));
        end
        else if (op_fire)
        begin
            res_valid_next = 1'b1;
            status_next    = ST_OK;
            vres_next      = '0;
            last_next      = 1'b1;
            unique case (mode_t'(mode))
                MODE_PUSH_FRONT, MODE_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd        = (mode_t'(mode) == MODE_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                       : CMD_PUSH_BACK;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd        = CMD_POP_FRONT;
                        vres_next  = cell_word[0];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd        = CMD_POP_BACK;
                        vres_next  = picked;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_DELETE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd = CMD_DELETE;
                        if (found)
                        begin
                            vres_next  = picked;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_NOTFOUND;
                        end
                    end
                end
                MODE_CLEAR: count_next = '0;
                MODE_READ_ALL:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        cmd            = CMD_ROTATE;
                        vres_next      = cell_word[0];
                        last_next      = (count_reg == CNT_W'(1));
                        rd_left_next   = count_reg - CNT_W'(1);
                        rd_active_next = (count_reg > CNT_W'(1));
                    end
                end
                default: status_next = ST_OK;
            endcase
            rcount_next = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_left_reg   <= '0;
            rd_active_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            rd_active_reg <= rd_active_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        vres_reg   <= vres_next;
        rcount_reg <= rcount_next;
        last_reg   <= last_next;
    end

    assign res_valid = res_valid_reg;
    assign status    = status_reg;
    assign value_res = vres_reg;
    assign count     = rcount_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/bdvd_checker.sv -----
// port-level checks for the bounded deque unit, bound to the top level
// depends on bdvd_pkg and the assertion macro header
`include "bounded_deque_with_value_delete_unit_defines.svh"

module bdvd_checker
    import bdvd_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          op_valid,
    input logic                          op_stall,
    input logic [MODE_W-1:0]             mode,
    input logic signed [WORD_W-1:0]      value,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic [STATUS_W-1:0]           status,
    input logic signed [WORD_W-1:0]      value_res,
    input logic [$clog2(CAPACITY+1)-1:0] count,
    input logic                          last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic unused_in;
    assign unused_in = op_valid ^ (^mode) ^ (^value);

    // count never passes capacity
    `BDVD_ASSERT_NOW(a_count_bound, res_valid, count <= CNT_W'(CAPACITY), "count above capacity")

    // only read all streams several words, and nothing else is taken meanwhile
    `BDVD_ASSERT_NOW(a_stream_blocks, res_valid && !last, op_stall, "op taken mid stream")

    // an error status always closes the op
    `BDVD_ASSERT_NOW(a_err_last, res_valid && (status != ST_OK), last,
        "error status without last")

    // stalled result word holds
    `BDVD_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(value_res) && $stable(status) && $stable(count) && $stable(last),
        "stalled result changed")

endmodule

bind bounded_deque_with_value_delete_unit bdvd_checker #(.CAPACITY(CAPACITY)) u_bdvd_checker (.*);

// ----- dv/bounded_deque_with_value_delete_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for bounded_deque_with_value_delete_unit: directed and random deque ops with
// bursty sender and stalling receiver, every result word checked against a queue-based predictor
// depends on bdvd_pkg and the rtl of the unit
module bounded_deque_with_value_delete_unit_tb;
    import bdvd_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int RANDOM_OPS = 250;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
        bit                       hold_off;
    } deque_op_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] value_res;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } deque_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     op_valid;
    logic                     op_stall;
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] value;
    logic                     res_valid;
    logic                     res_stall;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] value_res;
    logic [CNT_W-1:0]         count;
    logic                     last;

    deque_op_t                pending_ops[$];
    deque_word_t              due_words[$];
    logic signed [WORD_W-1:0] shadow_list[$];
    logic signed [WORD_W-1:0] pushed_words[$];

    deque_op_t   next_op;
    deque_word_t got_due;
    int          burst_left;
    int          gap_left;
    int          stall_phase;
    int          stall_timer;
    int          cycle_count;
    int          ops_taken;
    int          words_seen;
    int          mismatches;
    int          status_hits[4];

    bounded_deque_with_value_delete_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .mode      (mode),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .value_res (value_res),
        .count     (count),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic void add_result(status_t st, logic signed [WORD_W-1:0] v, bit lst);
        deque_word_t w;
        w.status = st;
        w.value_res = v;
        w.count = CNT_W'(shadow_list.size());
        w.last = lst;
        due_words.push_back(w);
    endfunction

    function automatic void apply_op(deque_op_t op);
        int hit;
        logic signed [WORD_W-1:0] v;
        hit = -1;
        case (op.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
                if (shadow_list.size() >= CAP)
                    add_result(ST_FULL, '0, 1'b1);
                else
                begin
                    if (op.mode == MODE_PUSH_FRONT)
                        shadow_list.push_front(op.value);
                    else
                        shadow_list.push_back(op.value);
                    add_result(ST_OK, '0, 1'b1);
                end
            MODE_POP_FRONT, MODE_POP_BACK:
                if (shadow_list.size() == 0)
                    add_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    if (op.mode == MODE_POP_FRONT)
                        v = shadow_list.pop_front();
                    else
                        v = shadow_list.pop_back();
                    add_result(ST_OK, v, 1'b1);
                end
            MODE_DELETE:
                if (shadow_list.size() == 0)
                    add_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < shadow_list.size() && hit < 0; i++)
                        if (shadow_list[i] == op.value)
                            hit = i;
                    if (hit < 0)
                        add_result(ST_NOTFOUND, '0, 1'b1);
                    else
                    begin
                        v = shadow_list[hit];
                        shadow_list.delete(hit);
                        add_result(ST_OK, v, 1'b1);
                    end
                end
            MODE_CLEAR:
            begin
                shadow_list.delete();
                add_result(ST_OK, '0, 1'b1);
            end
            MODE_READ_ALL:
                if (shadow_list.size() == 0)
                    add_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_list.size(); i++)
                        add_result(ST_OK, shadow_list[i], i == shadow_list.size() - 1);
            default:
                add_result(ST_OK, '0, 1'b1);
        endcase
    endfunction

    function automatic void add_op(logic [MODE_W-1:0] m, logic signed [WORD_W-1:0] v,
                                   bit hold = 1'b0);
        deque_op_t op;
        op.mode = m;
        op.value = v;
        op.hold_off = hold;
        pending_ops.push_back(op);
        if (m == MODE_PUSH_FRONT || m == MODE_PUSH_BACK)
        begin
            pushed_words.push_back(v);
            if (pushed_words.size() > 64)
                void'(pushed_words.pop_front());
        end
    endfunction

    // small values repeat often so that duplicate matches occur
    function automatic logic signed [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return $signed($urandom_range(0, 6)) - 3;
        else if (r == 3)
            return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
        else
            return $urandom;
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid <= 1'b0;
            mode <= MODE_PUSH_FRONT;
            value <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!op_valid || !op_stall)
        begin
            if (op_valid)
                ops_taken++;
            if (gap_left > 0)
            begin
                op_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_ops.size() == 0 ||
                     (pending_ops[0].hold_off && due_words.size() != 0))
                op_valid <= 1'b0;
            else
            begin
                next_op = pending_ops.pop_front();
                apply_op(next_op);
                op_valid <= 1'b1;
                mode <= next_op.mode;
                value <= next_op.value;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver: stall pattern switches between free, light, heavy and periodic
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_phase <= 0;
            stall_timer <= 0;
        end
        else
        begin
            if (stall_timer == 0)
            begin
                stall_phase <= $urandom_range(0, 3);
                stall_timer <= $urandom_range(20, 120);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_phase)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= ($urandom_range(0, 3) != 0);
                default: res_stall <= (cycle_count % 3 == 1);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            words_seen++;
            if (due_words.size() == 0)
            begin
                $display("%0t: word with none expected, expected none, actual %0h/%0h/%0h/%0h",
                         $time, status, value_res, count, last);
                mismatches++;
            end
            else
            begin
                got_due = due_words.pop_front();
                status_hits[got_due.status]++;
                check_field("status", WORD_W'(got_due.status), WORD_W'(status));
                check_field("value_res", got_due.value_res, value_res);
                check_field("count", WORD_W'(got_due.count), WORD_W'(count));
                check_field("last", WORD_W'(got_due.last), WORD_W'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d words still expected", $time, due_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int random_count;
        int phase;
        int seg_left;
        int push_pct;
        int rest;
        int r;
        logic [MODE_W-1:0] m;
        logic signed [WORD_W-1:0] v;

        rst_n = 1'b0;
        res_stall = 1'b0;
        op_valid = 1'b0;
        mode = MODE_PUSH_FRONT;
        value = '0;
        cycle_count = 0;
        ops_taken = 0;
        words_seen = 0;
        mismatches = 0;
        random_count = 0;
        seg_left = 0;
        push_pct = 42;

        // empty list cases, then extremes, duplicates and first-match delete
        add_op(MODE_READ_ALL, 0);
        add_op(MODE_POP_FRONT, 0);
        add_op(MODE_POP_BACK, 0);
        add_op(MODE_DELETE, 5);
        add_op(MODE_CLEAR, 0);
        add_op(MODE_PUSH_FRONT, WORD_MAX);
        add_op(MODE_PUSH_BACK, WORD_MIN);
        add_op(MODE_PUSH_FRONT, 0);
        add_op(MODE_PUSH_BACK, -1);
        add_op(MODE_PUSH_BACK, WORD_MAX);
        add_op(MODE_READ_ALL, 0);
        add_op(MODE_DELETE, 12345);
        add_op(MODE_DELETE, WORD_MAX);
        add_op(MODE_READ_ALL, 0, 1'b1);
        add_op(MODE_POP_FRONT, 0);
        add_op(MODE_POP_BACK, 0);
        add_op(MODE_UNUSED, WORD_MIN);
        add_op(MODE_READ_ALL, 0);
        add_op(MODE_CLEAR, 0);
        add_op(MODE_READ_ALL, 0);
        add_op(MODE_PUSH_BACK, 1);
        add_op(MODE_DELETE, 1);
        add_op(MODE_DELETE, 1);

        // fill past capacity, then read the full list
        for (int i = 0; i < CAP + 2; i++)
        begin
            add_op($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_word());
            random_count++;
        end
        add_op(MODE_READ_ALL, 0, 1'b1);
        add_op(MODE_DELETE, pushed_words[$urandom_range(0, pushed_words.size() - 1)]);
        add_op(MODE_READ_ALL, 0);
        random_count += 3;

        while (random_count < RANDOM_OPS)
        begin
            if (seg_left == 0)
            begin
                phase = $urandom_range(0, 2);
                push_pct = (phase == 0) ? 65 : (phase == 1) ? 20 : 42;
                seg_left = $urandom_range(10, 30);
            end
            seg_left--;
            rest = 97 - push_pct - 8;
            r = $urandom_range(0, 99);
            v = pick_word();
            if (r < push_pct)
                m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
            else if (r < push_pct + rest / 2)
                m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
            else if (r < push_pct + rest)
            begin
                m = MODE_DELETE;
                if (pushed_words.size() != 0 && $urandom_range(0, 9) < 7)
                    v = pushed_words[$urandom_range(0, pushed_words.size() - 1)];
            end
            else if (r < 97)
                m = MODE_READ_ALL;
            else if (r < 99)
                m = MODE_CLEAR;
            else
                m = MODE_UNUSED;
            add_op(m, v, $urandom_range(0, 99) < 3);
            if (m != MODE_UNUSED)
                random_count++;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || op_valid || due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d ops, %0d result words in %0d cycles", ops_taken, words_seen,
                 cycle_count);
        $display("replies: %0d ok, %0d empty, %0d full, %0d not found, %0d mismatches",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_FULL],
                 status_hits[ST_NOTFOUND], mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
